>>> hw/rtl/rpi_pkg.sv
// rpi_pkg: shared widths, item types and the return-period table
// for the return period interpolator. No dependencies.
`default_nettype none

package rpi_pkg;

  localparam int FRAC_BITS_DEF = 8;
  localparam int Q_W           = 31;
  localparam int THR0_W        = 32;
  localparam int OUT_W         = 17;
  localparam int NUM_W         = 32;
  localparam int SPAN_W        = 7;
  localparam int YEARS_W       = 8;
  localparam int BAND_W        = 3;
  localparam int NUM_THR       = 8;
  localparam int PROD_W        = NUM_W + SPAN_W;
  localparam int QUEUE_DEPTH   = 2;

  typedef enum logic [1:0] {
    KIND_NODATA,
    KIND_TOP,
    KIND_ZERO,
    KIND_INTERP
  } kind_e;

  typedef struct packed {
    kind_e                    kind;
    logic [BAND_W-1:0]        band;
    logic [Q_W-1:0]           q;
    logic signed [THR0_W:0]   lo;
    logic [Q_W-1:0]           hi;
  } rpi_item_t;

  function automatic logic [YEARS_W-1:0] band_years(input logic [BAND_W-1:0] idx);
    logic [YEARS_W-1:0] y;
    unique case (idx)
      3'd0: y = 8'd1;
      3'd1: y = 8'd2;
      3'd2: y = 8'd5;
      3'd3: y = 8'd10;
      3'd4: y = 8'd25;
      3'd5: y = 8'd50;
      3'd6: y = 8'd100;
      3'd7: y = 8'd200;
    endcase
    return y;
  endfunction

endpackage

`default_nettype wire

>>> hw/rtl/rpi_front.sv
// rpi_front: accepts items, classifies them and selects the band thresholds.
// Depends on rpi_pkg.
`default_nettype none

module rpi_front import rpi_pkg::*; #(
  parameter int unsigned FracBits = FRAC_BITS_DEF
) (
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,
  input  wire logic                     in_valid_i,
  output logic                          in_ready_o,
  input  wire logic [Q_W-1:0]           discharge_i,
  input  wire logic signed [THR0_W-1:0] thr_1yr_i,
  input  wire logic [Q_W-1:0]           thr_2yr_i,
  input  wire logic [Q_W-1:0]           thr_5yr_i,
  input  wire logic [Q_W-1:0]           thr_10yr_i,
  input  wire logic [Q_W-1:0]           thr_25yr_i,
  input  wire logic [Q_W-1:0]           thr_50yr_i,
  input  wire logic [Q_W-1:0]           thr_100yr_i,
  input  wire logic [Q_W-1:0]           thr_200yr_i,
  output logic                          item_valid_o,
  input  wire logic                     item_ready_i,
  output rpi_item_t                     item_o
);

  localparam logic [THR0_W-1:0] NODATA_THR = THR0_W'(0) - (THR0_W'(1) << FracBits);

  logic signed [THR0_W:0] thr [NUM_THR];
  logic signed [THR0_W:0] q_ext;
  logic [NUM_THR-1:0]     gt;
  logic [BAND_W-1:0]      hi_idx;
  rpi_item_t              item_d, item_q;
  logic                   valid_d, valid_q;
  logic                   load;

  always_comb begin
    thr[0] = {thr_1yr_i[THR0_W-1], thr_1yr_i};
    thr[1] = {2'b00, thr_2yr_i};
    thr[2] = {2'b00, thr_5yr_i};
    thr[3] = {2'b00, thr_10yr_i};
    thr[4] = {2'b00, thr_25yr_i};
    thr[5] = {2'b00, thr_50yr_i};
    thr[6] = {2'b00, thr_100yr_i};
    thr[7] = {2'b00, thr_200yr_i};
    q_ext  = {2'b00, discharge_i};
    for (int i = 0; i < NUM_THR; i++) begin
      gt[i] = q_ext > thr[i];
    end
  end

  always_comb begin
    item_d.kind = KIND_ZERO;
    item_d.band = '0;
    priority if (thr_1yr_i == NODATA_THR) begin
      item_d.kind = KIND_NODATA;
    end else if (gt[NUM_THR-1]) begin
      item_d.kind = KIND_TOP;
    end else begin
      // highest exceeded threshold wins
      for (int i = 0; i < NUM_THR - 1; i++) begin
        if (gt[i]) begin
          item_d.kind = KIND_INTERP;
          item_d.band = BAND_W'(i);
        end
      end
    end
    hi_idx    = BAND_W'(item_d.band + 1'b1);
    item_d.q  = discharge_i;
    item_d.lo = thr[item_d.band];
    item_d.hi = thr[hi_idx][Q_W-1:0];
  end

  assign in_ready_o   = !valid_q || item_ready_i;
  assign load         = in_valid_i && in_ready_o;
  assign valid_d      = load || (valid_q && !item_ready_i);
  assign item_valid_o = valid_q;
  assign item_o       = item_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      item_q <= item_d;
    end
  end

endmodule

`default_nettype wire

>>> hw/rtl/rpi_queue.sv
// rpi_queue: short FIFO of classified items between front and back.
// Depends on rpi_pkg.
`default_nettype none

module rpi_queue import rpi_pkg::*; (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       push_valid_i,
  output logic            push_ready_o,
  input  wire rpi_item_t  push_item_i,
  output logic            pop_valid_o,
  input  wire logic       pop_ready_i,
  output rpi_item_t       pop_item_o
);

  localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  rpi_item_t          mem_q [QUEUE_DEPTH];
  logic [PTR_W-1:0]   wr_ptr_d, wr_ptr_q, rd_ptr_d, rd_ptr_q;
  logic [CNT_W-1:0]   count_d, count_q;
  logic               push, pop;

  assign push_ready_o = count_q != CNT_W'(QUEUE_DEPTH);
  assign pop_valid_o  = count_q != '0;
  assign pop_item_o   = mem_q[rd_ptr_q];
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push) begin
      wr_ptr_d = (wr_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : PTR_W'(wr_ptr_q + 1'b1);
    end
    if (pop) begin
      rd_ptr_d = (rd_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : PTR_W'(rd_ptr_q + 1'b1);
    end
    if (push && !pop) begin
      count_d = CNT_W'(count_q + 1'b1);
    end else if (pop && !push) begin
      count_d = CNT_W'(count_q - 1'b1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= push_item_i;
    end
  end

endmodule

`default_nettype wire

>>> hw/rtl/rpi_back.sv
// rpi_back: band arithmetic, pipelined restoring divider (one quotient bit
// per stage) and output register. Depends on rpi_pkg.
`default_nettype none

module rpi_back import rpi_pkg::*; #(
  parameter int unsigned FracBits = FRAC_BITS_DEF
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  output logic                   in_ready_o,
  input  wire rpi_item_t         item_i,
  output logic                   out_valid_o,
  input  wire logic              out_ready_i,
  output logic signed [OUT_W-1:0] period_years_o
);

  localparam int QW    = SPAN_W + FracBits;
  localparam int RES_W = YEARS_W + FracBits + 1;
  localparam logic [RES_W-1:0] TWO_VAL    = RES_W'(2) << FracBits;
  localparam logic [RES_W-1:0] CLAMP_VAL  = RES_W'((199 << FracBits) / 100);
  localparam logic [RES_W-1:0] TOP_VAL    = RES_W'(200) << FracBits;
  localparam logic [OUT_W-1:0] NODATA_VAL = OUT_W'(0) - (OUT_W'(1) << FracBits);

  logic adv;

  // stage A: numerator, denominator, span
  logic                  a_valid_q;
  kind_e                 a_kind_q;
  logic [BAND_W-1:0]     a_band_q;
  logic [NUM_W-1:0]      a_num_q, a_den_q, a_num_d, a_den_d;
  logic [SPAN_W-1:0]     a_span_q, a_span_d;
  logic signed [THR0_W:0] num_full, den_full;
  logic [BAND_W-1:0]     hi_band;
  logic [YEARS_W-1:0]    span_full;

  // divider stages, index 0 holds the initial remainder
  logic                  d_valid_q [QW+1];
  kind_e                 d_kind_q  [QW+1];
  logic [BAND_W-1:0]     d_band_q  [QW+1];
  logic [NUM_W-1:0]      d_den_q   [QW+1];
  logic [NUM_W-1:0]      d_rem_q   [QW+1];
  logic [QW-1:0]         d_rq_q    [QW+1];
  logic [PROD_W-1:0]     prod;
  logic [NUM_W-1:0]      step_rem  [1:QW];
  logic [QW-1:0]         step_rq   [1:QW];

  // output
  logic                  out_valid_q;
  logic [OUT_W-1:0]      out_d, out_q;
  logic [RES_W-1:0]      res;

  assign adv        = !out_valid_q || out_ready_i;
  assign in_ready_o = adv;

  always_comb begin
    num_full  = $signed({2'b00, item_i.q}) - item_i.lo;
    den_full  = $signed({2'b00, item_i.hi}) - item_i.lo;
    a_num_d   = num_full[NUM_W-1:0];
    a_den_d   = den_full[NUM_W-1:0];
    hi_band   = BAND_W'(item_i.band + 1'b1);
    span_full = band_years(hi_band) - band_years(item_i.band);
    a_span_d  = span_full[SPAN_W-1:0];
  end

  assign prod = PROD_W'(a_num_q) * PROD_W'(a_span_q);

  always_comb begin
    logic [NUM_W:0] r2;
    logic           ge;
    for (int s = 1; s <= QW; s++) begin
      r2 = {d_rem_q[s-1], d_rq_q[s-1][QW-1]};
      ge = r2 >= {1'b0, d_den_q[s-1]};
      step_rem[s] = ge ? NUM_W'(r2 - {1'b0, d_den_q[s-1]}) : r2[NUM_W-1:0];
      step_rq[s]  = {d_rq_q[s-1][QW-2:0], ge};
    end
  end

  always_comb begin
    res = (RES_W'(band_years(d_band_q[QW])) << FracBits) + RES_W'(d_rq_q[QW]);
    if (d_band_q[QW] == '0 && res >= TWO_VAL) begin
      res = CLAMP_VAL;
    end
    unique case (d_kind_q[QW])
      KIND_NODATA: out_d = NODATA_VAL;
      KIND_TOP:    out_d = OUT_W'(TOP_VAL);
      KIND_ZERO:   out_d = '0;
      KIND_INTERP: out_d = OUT_W'(res);
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_valid_q   <= 1'b0;
      out_valid_q <= 1'b0;
      for (int s = 0; s <= QW; s++) begin
        d_valid_q[s] <= 1'b0;
      end
    end else if (adv) begin
      a_valid_q    <= in_valid_i;
      d_valid_q[0] <= a_valid_q;
      for (int s = 1; s <= QW; s++) begin
        d_valid_q[s] <= d_valid_q[s-1];
      end
      out_valid_q  <= d_valid_q[QW];
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      a_kind_q    <= item_i.kind;
      a_band_q    <= item_i.band;
      a_num_q     <= a_num_d;
      a_den_q     <= a_den_d;
      a_span_q    <= a_span_d;
      d_kind_q[0] <= a_kind_q;
      d_band_q[0] <= a_band_q;
      d_den_q[0]  <= a_den_q;
      d_rem_q[0]  <= prod[PROD_W-1:SPAN_W];
      d_rq_q[0]   <= {prod[SPAN_W-1:0], FracBits'(0)};
      for (int s = 1; s <= QW; s++) begin
        d_kind_q[s] <= d_kind_q[s-1];
        d_band_q[s] <= d_band_q[s-1];
        d_den_q[s]  <= d_den_q[s-1];
        d_rem_q[s]  <= step_rem[s];
        d_rq_q[s]   <= step_rq[s];
      end
      out_q <= out_d;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign period_years_o = $signed(out_q);

endmodule

`default_nettype wire

>>> hw/rtl/return_period_interpolator_core.sv
// return_period_interpolator_core: top level, front classifier, item queue
// and arithmetic back end. Depends on rpi_pkg, rpi_front, rpi_queue, rpi_back.
//
//   channel | handshake                  | payload
//   in      | in_valid_i / in_ready_o    | discharge_i, thr_1yr_i .. thr_200yr_i
//   out     | out_valid_o / out_ready_i  | period_years_o
//
// One item per cycle sustained while out_ready_i stays high; the divider retires
// one quotient bit per stage (FracBits + 7 stages).
// Reset is asynchronous and clears all valid and pointer state; no clearing pass.
// A stall on out_ready_i freezes the back end; the queue and the front register
// keep accepting until full.
`default_nettype none

module return_period_interpolator_core import rpi_pkg::*; #(
  parameter int unsigned FracBits = FRAC_BITS_DEF
) (
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,
  input  wire logic                     in_valid_i,
  output logic                          in_ready_o,
  input  wire logic [Q_W-1:0]           discharge_i,
  input  wire logic signed [THR0_W-1:0] thr_1yr_i,
  input  wire logic [Q_W-1:0]           thr_2yr_i,
  input  wire logic [Q_W-1:0]           thr_5yr_i,
  input  wire logic [Q_W-1:0]           thr_10yr_i,
  input  wire logic [Q_W-1:0]           thr_25yr_i,
  input  wire logic [Q_W-1:0]           thr_50yr_i,
  input  wire logic [Q_W-1:0]           thr_100yr_i,
  input  wire logic [Q_W-1:0]           thr_200yr_i,
  output logic                          out_valid_o,
  input  wire logic                     out_ready_i,
  output logic signed [OUT_W-1:0]       period_years_o
);

  logic      f_valid, f_ready;
  rpi_item_t f_item;
  logic      b_valid, b_ready;
  rpi_item_t b_item;

  rpi_front #(.FracBits(FracBits)) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .discharge_i  (discharge_i),
    .thr_1yr_i    (thr_1yr_i),
    .thr_2yr_i    (thr_2yr_i),
    .thr_5yr_i    (thr_5yr_i),
    .thr_10yr_i   (thr_10yr_i),
    .thr_25yr_i   (thr_25yr_i),
    .thr_50yr_i   (thr_50yr_i),
    .thr_100yr_i  (thr_100yr_i),
    .thr_200yr_i  (thr_200yr_i),
    .item_valid_o (f_valid),
    .item_ready_i (f_ready),
    .item_o       (f_item)
  );

  rpi_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (f_valid),
    .push_ready_o (f_ready),
    .push_item_i  (f_item),
    .pop_valid_o  (b_valid),
    .pop_ready_i  (b_ready),
    .pop_item_o   (b_item)
  );

  rpi_back #(.FracBits(FracBits)) u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (b_valid),
    .in_ready_o     (b_ready),
    .item_i         (b_item),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .period_years_o (period_years_o)
  );

endmodule

`default_nettype wire

>>> hw/rtl/rpi_checker.sv
// rpi_checker: port-level assertions for return_period_interpolator_core,
// bound to the top level. Depends on rpi_pkg.
`default_nettype none

module rpi_checker import rpi_pkg::*; #(
  parameter int unsigned FracBits = FRAC_BITS_DEF
) (
  input wire logic                     clk_i,
  input wire logic                     rst_ni,
  input wire logic                     in_valid_i,
  input wire logic                     in_ready_o,
  input wire logic [Q_W-1:0]           discharge_i,
  input wire logic signed [THR0_W-1:0] thr_1yr_i,
  input wire logic [Q_W-1:0]           thr_2yr_i,
  input wire logic [Q_W-1:0]           thr_5yr_i,
  input wire logic [Q_W-1:0]           thr_10yr_i,
  input wire logic [Q_W-1:0]           thr_25yr_i,
  input wire logic [Q_W-1:0]           thr_50yr_i,
  input wire logic [Q_W-1:0]           thr_100yr_i,
  input wire logic [Q_W-1:0]           thr_200yr_i,
  input wire logic                     out_valid_o,
  input wire logic                     out_ready_i,
  input wire logic signed [OUT_W-1:0]  period_years_o
);

  localparam int CAP   = SPAN_W + FracBits + QUEUE_DEPTH + 4;
  localparam int PND_W = $clog2(CAP + 2);
  localparam bit RangeOk = (200 << FracBits) < (1 << (OUT_W - 1));

  logic [PND_W-1:0] pending_d, pending_q;
  logic             in_xfer, out_xfer;

  assign in_xfer  = in_valid_i && in_ready_o;
  assign out_xfer = out_valid_o && out_ready_i;

  always_comb begin
    pending_d = pending_q;
    if (in_xfer && !out_xfer) begin
      pending_d = PND_W'(pending_q + 1'b1);
    end else if (out_xfer && !in_xfer) begin
      pending_d = PND_W'(pending_q - 1'b1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pending_q <= '0;
    end else begin
      pending_q <= pending_d;
    end
  end

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(period_years_o))
    else $error("result dropped or changed while stalled");

  a_no_invent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> pending_q != '0)
    else $error("result without an outstanding item");

  a_capacity: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pending_q <= PND_W'(CAP))
    else $error("more items in flight than the pipeline holds");

  a_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && RangeOk |->
      (int'(period_years_o) >= -(1 << FracBits)) &&
      (int'(period_years_o) <= (200 << FracBits)))
    else $error("return period out of range");

  logic unused_ok;
  assign unused_ok = ^{discharge_i, thr_1yr_i, thr_2yr_i, thr_5yr_i, thr_10yr_i,
                       thr_25yr_i, thr_50yr_i, thr_100yr_i, thr_200yr_i};

endmodule

bind return_period_interpolator_core rpi_checker #(.FracBits(FracBits)) u_rpi_checker (.*);

`default_nettype wire

>>> bench/rpi_period_checker.sv
`timescale 1ns / 1ps
// rpi_period_checker: watches both channels of the return period interpolator,
// predicts each return period and compares it with the block's output.
// Depends on rpi_pkg.
module rpi_period_checker import rpi_pkg::*; #(
  parameter int unsigned FracBits = FRAC_BITS_DEF
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     in_valid_i,
  input  logic                     in_ready_i,
  input  logic [Q_W-1:0]           discharge_i,
  input  logic [THR0_W-1:0]        thr_1yr_i,
  input  logic [Q_W-1:0]           thr_2yr_i,
  input  logic [Q_W-1:0]           thr_5yr_i,
  input  logic [Q_W-1:0]           thr_10yr_i,
  input  logic [Q_W-1:0]           thr_25yr_i,
  input  logic [Q_W-1:0]           thr_50yr_i,
  input  logic [Q_W-1:0]           thr_100yr_i,
  input  logic [Q_W-1:0]           thr_200yr_i,
  input  logic                     out_valid_i,
  input  logic                     out_ready_i,
  input  logic signed [OUT_W-1:0]  period_years_i,
  output int unsigned              fail_cnt_o,
  output int unsigned              pending_cnt_o,
  output int unsigned              checked_cnt_o
);

  localparam logic [NUM_THR*8-1:0] PeriodYears =
    {8'd200, 8'd100, 8'd50, 8'd25, 8'd10, 8'd5, 8'd2, 8'd1};

  logic signed [OUT_W-1:0] period_q [$];
  int unsigned fail_cnt = 0;
  int unsigned checked_cnt = 0;
  int unsigned pending_cnt = 0;

  assign fail_cnt_o    = fail_cnt;
  assign checked_cnt_o = checked_cnt;
  assign pending_cnt_o = pending_cnt;

  function automatic logic signed [OUT_W-1:0] classify_period(
    input logic [Q_W-1:0]    flow_in,
    input logic [THR0_W-1:0] ladder [NUM_THR]
  );
    longint flow;
    longint bound [NUM_THR];
    longint one;
    longint unsigned num, den, span, frac, res, yr_lo, yr_hi;
    flow = longint'(flow_in);
    bound[0] = longint'($signed(ladder[0]));
    for (int i = 1; i < NUM_THR; i++) begin
      bound[i] = longint'(ladder[i][Q_W-1:0]);
    end
    one = longint'(1) << FracBits;
    if (bound[0] == -one) begin
      res = longint'(-one);
      return res[OUT_W-1:0];
    end
    if (flow > bound[NUM_THR-1]) begin
      res = longint'(PeriodYears[(NUM_THR-1)*8 +: 8]) << FracBits;
      return res[OUT_W-1:0];
    end
    for (int b = NUM_THR - 2; b >= 0; b--) begin
      if (flow > bound[b]) begin
        yr_lo = longint'(PeriodYears[b*8 +: 8]);
        yr_hi = longint'(PeriodYears[(b+1)*8 +: 8]);
        num   = flow - bound[b];
        den   = bound[b+1] - bound[b];
        span  = yr_hi - yr_lo;
        frac  = (den != 0) ? ((num * span) << FracBits) / den : 0;
        res   = (yr_lo << FracBits) + frac;
        // first band never reports 2.0 or more
        if (b == 0 && res >= (longint'(2) << FracBits)) begin
          res = (longint'(199) << FracBits) / 100;
        end
        return res[OUT_W-1:0];
      end
    end
    return '0;
  endfunction

  always @(posedge clk_i) begin : watch
    logic [THR0_W-1:0]       ladder [NUM_THR];
    logic signed [OUT_W-1:0] want;
    if (rst_ni) begin
      if (out_valid_i && out_ready_i) begin
        checked_cnt++;
        if (period_q.size() == 0) begin
          fail_cnt++;
          $error("period_years: no pending transfer, got %0d", period_years_i);
        end else begin
          want = period_q.pop_front();
          if (want !== period_years_i) begin
            fail_cnt++;
            $error("period_years: expected %0d, got %0d", want, period_years_i);
          end
        end
      end
      if (in_valid_i && in_ready_i) begin
        ladder = '{thr_1yr_i, thr_2yr_i, thr_5yr_i, thr_10yr_i, thr_25yr_i,
                   thr_50yr_i, thr_100yr_i, thr_200yr_i};
        period_q.push_back(classify_period(discharge_i, ladder));
      end
      pending_cnt <= period_q.size();
    end
  end

endmodule

>>> bench/return_period_interpolator_core_tb.sv
`timescale 1ns / 1ps
// return_period_interpolator_core_tb: clock, reset, stimulus and verdict for
// the return period interpolator. Depends on rpi_pkg, the core and rpi_period_checker.
module return_period_interpolator_core_tb;
  import rpi_pkg::*;

  localparam int unsigned FracBits    = FRAC_BITS_DEF;
  localparam int unsigned Latency     = FracBits + 11;
  localparam int unsigned IdleLimit   = 2000;
  localparam int unsigned RandomItems = 1700;
  localparam int          NoData      = -(1 << FracBits);
  localparam longint      MaxFlow     = (longint'(1) << Q_W) - 1;
  localparam longint      MinThr      = -(longint'(1) << (THR0_W - 1));

  logic clk;
  logic rst_n;
  logic in_valid, in_ready, out_valid, out_ready;
  logic [Q_W-1:0] discharge;
  logic [THR0_W-1:0] thr_drv [NUM_THR];
  logic signed [OUT_W-1:0] period_years;

  logic [Q_W-1:0] flow_gen;
  logic [THR0_W-1:0] thr_gen [NUM_THR];
  bit send_burst, take_burst;
  int unsigned sent_cnt, directed_cnt, idle_cycles;
  int unsigned fail_cnt, pending_cnt, checked_cnt;

  return_period_interpolator_core #(.FracBits(FracBits)) dut (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .in_valid_i     (in_valid),
    .in_ready_o     (in_ready),
    .discharge_i    (discharge),
    .thr_1yr_i      (thr_drv[0]),
    .thr_2yr_i      (thr_drv[1][Q_W-1:0]),
    .thr_5yr_i      (thr_drv[2][Q_W-1:0]),
    .thr_10yr_i     (thr_drv[3][Q_W-1:0]),
    .thr_25yr_i     (thr_drv[4][Q_W-1:0]),
    .thr_50yr_i     (thr_drv[5][Q_W-1:0]),
    .thr_100yr_i    (thr_drv[6][Q_W-1:0]),
    .thr_200yr_i    (thr_drv[7][Q_W-1:0]),
    .out_valid_o    (out_valid),
    .out_ready_i    (out_ready),
    .period_years_o (period_years)
  );

  rpi_period_checker #(.FracBits(FracBits)) u_checker (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .in_valid_i     (in_valid),
    .in_ready_i     (in_ready),
    .discharge_i    (discharge),
    .thr_1yr_i      (thr_drv[0]),
    .thr_2yr_i      (thr_drv[1][Q_W-1:0]),
    .thr_5yr_i      (thr_drv[2][Q_W-1:0]),
    .thr_10yr_i     (thr_drv[3][Q_W-1:0]),
    .thr_25yr_i     (thr_drv[4][Q_W-1:0]),
    .thr_50yr_i     (thr_drv[5][Q_W-1:0]),
    .thr_100yr_i    (thr_drv[6][Q_W-1:0]),
    .thr_200yr_i    (thr_drv[7][Q_W-1:0]),
    .out_valid_i    (out_valid),
    .out_ready_i    (out_ready),
    .period_years_i (period_years),
    .fail_cnt_o     (fail_cnt),
    .pending_cnt_o  (pending_cnt),
    .checked_cnt_o  (checked_cnt)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && in_ready) || (out_valid && out_ready)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
      end
      if (idle_cycles >= IdleLimit) begin
        $display("RESULT: ERROR");
        $finish;
      end
    end
  end

  // result side: random stall before each transfer, with bursts of no stalls
  initial begin
    int unsigned stall;
    out_ready  = 1'b0;
    take_burst = 1'b0;
    wait (rst_n === 1'b1);
    forever begin
      if ($urandom_range(0, 39) == 0) take_burst = !take_burst;
      stall = take_burst ? 0 : $urandom_range(0, 13);
      if (stall != 0) begin
        out_ready = 1'b0;
        repeat (stall) @(negedge clk);
      end
      out_ready = 1'b1;
      do @(posedge clk); while (!out_valid);
      @(negedge clk);
    end
  end

  task automatic send_item();
    int unsigned gap;
    if ($urandom_range(0, 39) == 0) send_burst = !send_burst;
    gap = send_burst ? 0 : $urandom_range(0, 13);
    if (gap != 0) begin
      in_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    discharge = flow_gen;
    thr_drv   = thr_gen;
    in_valid  = 1'b1;
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
    sent_cnt++;
  endtask

  // thresholds: 1-year at t0, the rest at base + i * step
  task automatic send_ladder(input longint flow, input longint t0,
                             input longint base, input longint step);
    longint val;
    thr_gen[0] = t0[THR0_W-1:0];
    for (int i = 1; i < NUM_THR; i++) begin
      val = base + i * step;
      thr_gen[i] = val[THR0_W-1:0];
    end
    flow_gen = flow[Q_W-1:0];
    send_item();
  endtask

  task automatic make_ladder();
    int unsigned vals [NUM_THR];
    int unsigned w, mask, tmp;
    w = $urandom_range(1, Q_W);
    mask = (32'h1 << w) - 1;
    for (int i = 0; i < NUM_THR; i++) vals[i] = $urandom & mask;
    for (int i = 0; i < NUM_THR - 1; i++) begin
      for (int j = 0; j < NUM_THR - 1 - i; j++) begin
        if (vals[j] > vals[j+1]) begin
          tmp = vals[j];
          vals[j] = vals[j+1];
          vals[j+1] = tmp;
        end
      end
    end
    for (int i = 0; i < NUM_THR; i++) thr_gen[i] = vals[i];
    if ($urandom_range(0, 7) == 0) thr_gen[0] = -$urandom_range(32'h8000_0000, 1);
  endtask

  task automatic pick_flow();
    longint lo_b, hi_b, lower, top, flow;
    int unsigned band;
    band = $urandom_range(0, NUM_THR - 2);
    lo_b = (band == 0) ? longint'($signed(thr_gen[0])) : longint'(thr_gen[band][Q_W-1:0]);
    hi_b = longint'(thr_gen[band+1][Q_W-1:0]);
    top  = longint'(thr_gen[NUM_THR-1][Q_W-1:0]);
    lower = (lo_b + 1 < 0) ? 0 : lo_b + 1;
    case ($urandom_range(0, 9))
      0: flow = longint'($urandom);
      1: flow = hi_b;
      2: flow = (lower > MaxFlow) ? MaxFlow : lower;
      3: flow = (top == MaxFlow) ? MaxFlow : $urandom_range(32'(MaxFlow), 32'(top + 1));
      4: flow = (lo_b < 0) ? 0 : longint'($urandom_range(32'(lo_b), 0));
      default: flow = (hi_b >= lower) ? $urandom_range(32'(hi_b), 32'(lower)) : hi_b;
    endcase
    flow_gen = flow[Q_W-1:0];
  endtask

  initial begin
    int unsigned mask;
    rst_n       = 1'b0;
    in_valid    = 1'b0;
    discharge   = '0;
    thr_drv     = '{default: '0};
    send_burst  = 1'b0;
    sent_cnt    = 0;
    idle_cycles = 0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // no-data marker and its neighbors
    send_ladder(12345, NoData, 0, 1000);
    send_ladder(MaxFlow, NoData, MaxFlow, 0);
    send_ladder(0, NoData + 1, 0, 1000);
    send_ladder(0, NoData - 1, 0, 1000);
    // at or below the 1-year threshold
    send_ladder(0, 0, 0, 1000);
    send_ladder(500, 500, 500, 1000);
    // first band, with the clamp below 2.0
    send_ladder(501, 500, 500, 1000);
    send_ladder(1, 0, 0, 1);
    send_ladder(1500, 500, 500, 1000);
    // exactly on each upper threshold
    for (int b = 1; b < NUM_THR; b++) send_ladder(1000 + 1000 * b, 1000, 1000, 1000);
    // above the top, and full-scale values
    send_ladder(8001, 1000, 1000, 1000);
    send_ladder(MaxFlow, MaxFlow - 7000, MaxFlow - 7000, 1000);
    send_ladder(0, MaxFlow, MaxFlow, 0);
    send_ladder(MaxFlow - 8, MinThr, MaxFlow - 8, 1);
    // degenerate and descending ladders
    send_ladder(700, 700, 700, 0);
    send_ladder(701, 700, 700, 0);
    send_ladder(5000, 9000, 9000, -1000);
    directed_cnt = sent_cnt;

    for (int n = 0; n < RandomItems; n++) begin
      case ($urandom_range(0, 19))
        15, 16: begin
          for (int i = 0; i < NUM_THR; i++) thr_gen[i] = $urandom;
          flow_gen = Q_W'($urandom);
        end
        17: begin
          make_ladder();
          pick_flow();
          thr_gen[0] = NoData;
        end
        18, 19: begin
          mask = (32'h1 << $urandom_range(1, 12)) - 1;
          for (int i = 0; i < NUM_THR; i++) thr_gen[i] = $urandom & mask;
          if ($urandom_range(0, 3) == 0) thr_gen[0] = -$urandom_range(mask + 1, 1);
          flow_gen = Q_W'($urandom & mask);
        end
        default: begin
          make_ladder();
          pick_flow();
        end
      endcase
      send_item();
    end
    in_valid = 1'b0;

    while (pending_cnt != 0) @(posedge clk);
    repeat (Latency + 8) @(posedge clk);

    $display("Sent %0d discharge items (%0d directed, rest random ladders,", sent_cnt,
             directed_cnt);
    $display("raw and unsorted sets); %0d return periods compared.", checked_cnt);
    if (fail_cnt == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

>>> files.f
hw/rtl/rpi_pkg.sv
hw/rtl/rpi_front.sv
hw/rtl/rpi_queue.sv
hw/rtl/rpi_back.sv
hw/rtl/return_period_interpolator_core.sv
hw/rtl/rpi_checker.sv
bench/rpi_period_checker.sv
bench/return_period_interpolator_core_tb.sv
